[rtl/core/lfk_pkg.sv]
// shared types, constants and the q14 product helper for the leg kinematics block
// no dependencies; used by every module under rtl/core

package lfk_pkg;

    typedef logic signed [16:0] ang_t;
    typedef logic signed [15:0] trig_val_t;
    typedef logic signed [23:0] op_t;

    localparam ang_t ANG_PI     = 17'sd25736;
    localparam ang_t ANG_HALF   = 17'sd12868;
    localparam logic signed [17:0] ANG_TWO_PI = 18'sd51472;

    localparam logic [29:0] Q29_ONE = 30'd536870912;

    // round-up reciprocals, exact floor division for 31-bit dividends
    localparam int unsigned DIV42_SH = 37;
    localparam int unsigned DIV20_SH = 36;
    localparam int unsigned DIV6_SH  = 34;
    localparam logic [31:0] RECIP_42 = 32'(((64'd1 << 37) / 64'd42) + 64'd1);
    localparam logic [31:0] RECIP_20 = 32'(((64'd1 << 36) / 64'd20) + 64'd1);
    localparam logic [31:0] RECIP_6  = 32'(((64'd1 << 34) / 64'd6) + 64'd1);

    localparam logic [14:0] TRIG_CAP = 15'd16384;

    localparam op_t ROT_MAX = 24'sd16384;
    localparam op_t ROT_MIN = -24'sd16384;
    localparam op_t POS_MAX = 24'sd262143;
    localparam op_t POS_MIN = -24'sd262144;

    localparam int unsigned SINE_DEPTH = 9;
    localparam int unsigned KIN_DEPTH  = 6;
    localparam int unsigned PIPE_DEPTH = SINE_DEPTH + KIN_DEPTH;

    localparam logic [1:0] REG_THIGH = 2'd0;
    localparam logic [1:0] REG_CALF  = 2'd1;
    localparam logic [1:0] REG_ANKLE = 2'd2;

    typedef struct packed {
        trig_val_t [5:0] sn;
        trig_val_t [5:0] cs;
    } trig_set_t;

    typedef struct packed {
        logic [15:0] thigh;
        logic [15:0] calf;
        logic [15:0] ankle;
    } len_cfg_t;

    typedef struct packed {
        op_t r11;
        op_t r12;
        op_t r13;
        op_t r21;
        op_t r22;
        op_t r23;
        op_t r31;
        op_t r32;
        op_t r33;
        op_t px;
        op_t py;
        op_t pz;
    } kin_res_t;

    // floor((p*q + 8192) / 16384)
    function automatic op_t qmul(input op_t p, input op_t q);
        logic signed [47:0] prod;
        prod = (p * q) + 48'sd8192;
        return op_t'(prod >>> 14);
    endfunction

endpackage

[rtl/core/lfk_sine.sv]
// nine-stage fixed-point sine, q3.13 angle in, q1.14 value out
// depends on lfk_pkg

module lfk_sine (
    input  logic                aclk,
    input  logic                en,
    input  lfk_pkg::ang_t       angle,
    output lfk_pkg::trig_val_t  result
);

    logic signed [17:0] wrap_w;
    logic        [14:0] mag_w;
    logic        [13:0] fold_w;

    logic [13:0] u0_reg, u1_reg, u2_reg, u3_reg, u4_reg, u5_reg, u6_reg;
    logic        n0_reg, n1_reg, n2_reg, n3_reg, n4_reg, n5_reg, n6_reg, n7_reg;
    logic [30:0] x2_1_reg, x2_2_reg, x2_3_reg, x2_4_reg;
    logic [25:0] q42_reg;
    logic [30:0] p1_reg, p2_reg;
    logic [26:0] q20_reg;
    logic [29:0] c_reg;
    logic [29:0] s_reg;
    logic signed [15:0] result_reg;

    logic [62:0] q42_prod;
    logic [60:0] p1_prod;
    logic [62:0] q20_prod;
    logic [60:0] p2_prod;
    logic [62:0] q6_prod;
    logic [29:0] a_coef, b_coef;
    logic [43:0] s_prod;
    logic [15:0] rnd;
    logic [14:0] capped;

    always_comb begin
        if ($signed({angle[16], angle}) > $signed({lfk_pkg::ANG_PI[16], lfk_pkg::ANG_PI})) begin
            wrap_w = {angle[16], angle} - lfk_pkg::ANG_TWO_PI;
        end else if ($signed({angle[16], angle}) < -$signed({1'b0, lfk_pkg::ANG_PI})) begin
            wrap_w = {angle[16], angle} + lfk_pkg::ANG_TWO_PI;
        end else begin
            wrap_w = {angle[16], angle};
        end
        mag_w = wrap_w[17] ? 15'(-wrap_w) : wrap_w[14:0];
        if (mag_w > 15'(lfk_pkg::ANG_HALF)) begin
            fold_w = 14'(15'(lfk_pkg::ANG_PI) - mag_w);
        end else begin
            fold_w = mag_w[13:0];
        end
    end

    always_comb begin
        q42_prod = 63'(x2_1_reg) * 63'(lfk_pkg::RECIP_42);
        a_coef   = lfk_pkg::Q29_ONE - 30'(q42_reg);
        p1_prod  = 61'(x2_2_reg) * 61'(a_coef);
        q20_prod = 63'(p1_reg) * 63'(lfk_pkg::RECIP_20);
        b_coef   = lfk_pkg::Q29_ONE - 30'(q20_reg);
        p2_prod  = 61'(x2_4_reg) * 61'(b_coef);
        q6_prod  = 63'(p2_reg) * 63'(lfk_pkg::RECIP_6);
        s_prod   = 44'(u6_reg) * 44'(c_reg);
        rnd      = 16'((31'(s_reg) + 31'd16384) >> 15);
        capped   = (rnd > 16'(lfk_pkg::TRIG_CAP)) ? lfk_pkg::TRIG_CAP : rnd[14:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // fold into the first quadrant
            u0_reg   <= fold_w;
            n0_reg   <= wrap_w[17];
            // x2 = (u << 16)^2 >> 29
            x2_1_reg <= {28'(u0_reg) * 28'(u0_reg), 3'b000};
            u1_reg   <= u0_reg;
            n1_reg   <= n0_reg;
            q42_reg  <= 26'(q42_prod >> lfk_pkg::DIV42_SH);
            x2_2_reg <= x2_1_reg;
            u2_reg   <= u1_reg;
            n2_reg   <= n1_reg;
            p1_reg   <= 31'(p1_prod >> 29);
            x2_3_reg <= x2_2_reg;
            u3_reg   <= u2_reg;
            n3_reg   <= n2_reg;
            q20_reg  <= 27'(q20_prod >> lfk_pkg::DIV20_SH);
            x2_4_reg <= x2_3_reg;
            u4_reg   <= u3_reg;
            n4_reg   <= n3_reg;
            p2_reg   <= 31'(p2_prod >> 29);
            u5_reg   <= u4_reg;
            n5_reg   <= n4_reg;
            c_reg    <= lfk_pkg::Q29_ONE - 30'(q6_prod >> lfk_pkg::DIV6_SH);
            u6_reg   <= u5_reg;
            n6_reg   <= n5_reg;
            s_reg    <= 30'(s_prod >> 13);
            n7_reg   <= n6_reg;
            result_reg <= n7_reg ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
        end
    end

    assign result = result_reg;

endmodule

[rtl/core/lfk_kinematics.sv]
// six-stage product and sum pipeline: rotation rows, cross product row, foot position
// depends on lfk_pkg

module lfk_kinematics (
    input  logic                aclk,
    input  logic                en,
    input  lfk_pkg::trig_set_t  trig,
    input  lfk_pkg::len_cfg_t   lens,
    output lfk_pkg::kin_res_t   res
);

    lfk_pkg::op_t s1, c1, s2, c2, s3, c3, s4, c4, s5, c5, s6, c6;
    lfk_pkg::op_t th, ca, an;

    // stage a
    lfk_pkg::op_t a_s1c3_reg, a_c4c5_reg, a_s4s5_reg, a_s1s3_reg, a_s4c5_reg, a_c4s5_reg;
    lfk_pkg::op_t a_c1c2_reg, a_s3c1_reg, a_c1s2_reg, a_s2s3_reg, a_s2c3_reg, a_s1c2_reg;
    lfk_pkg::op_t a_c1s3_reg, a_s3s1_reg, a_c1c3_reg, a_c2s6_reg, a_c2c6_reg;
    lfk_pkg::op_t a_kc_reg, a_ko_reg, a_c2_reg, a_c3_reg, a_c6_reg, a_s6_reg;
    // stage b
    lfk_pkg::op_t b_c1c2c3_reg, b_s3c1c2_reg, b_s1c2c3_reg, b_s3s1c2_reg;
    lfk_pkg::op_t b_c1s2s6_reg, b_c1s2c6_reg, b_s2c3c6_reg, b_s2c3s6_reg;
    lfk_pkg::op_t b_dif_reg, b_sum_reg, b_ms2s3_reg, b_leg_reg, b_ko_reg;
    lfk_pkg::op_t b_s1s3_reg, b_s1c3_reg, b_c1s3_reg, b_c1c3_reg, b_s2c3_reg;
    lfk_pkg::op_t b_c2s6_reg, b_c2c6_reg, b_c6_reg, b_s6_reg;
    // stage c
    lfk_pkg::op_t c_ra_reg, c_rb_reg, c_ya_reg, c_yb_reg;
    lfk_pkg::op_t c_m31_reg, c_m32_reg, c_t31_reg, c_t32_reg, c_r33_reg, c_pxa_reg;
    lfk_pkg::op_t c_dif_reg, c_sum_reg, c_leg_reg, c_ko_reg;
    lfk_pkg::op_t c_c1s2s6_reg, c_c1s2c6_reg, c_c2s6_reg, c_c2c6_reg, c_c6_reg, c_s6_reg;
    // stage d
    lfk_pkg::op_t d_x1_reg, d_x2_reg, d_x3_reg, d_x4_reg;
    lfk_pkg::op_t d_r13_reg, d_r31_reg, d_r32_reg, d_r33_reg;
    lfk_pkg::op_t d_pxa_reg, d_pya_reg, d_pza_reg;
    lfk_pkg::op_t d_c1s2s6_reg, d_c1s2c6_reg, d_c6_reg, d_s6_reg;
    // stage e
    lfk_pkg::op_t e_r11_reg, e_r12_reg, e_r13_reg, e_r31_reg, e_r32_reg, e_r33_reg;
    lfk_pkg::op_t e_px_reg, e_pya_reg, e_pza_reg;
    // stage f
    lfk_pkg::kin_res_t f_res_reg;

    always_comb begin
        s1 = lfk_pkg::op_t'($signed(trig.sn[0]));
        s2 = lfk_pkg::op_t'($signed(trig.sn[1]));
        s3 = lfk_pkg::op_t'($signed(trig.sn[2]));
        s4 = lfk_pkg::op_t'($signed(trig.sn[3]));
        s5 = lfk_pkg::op_t'($signed(trig.sn[4]));
        s6 = lfk_pkg::op_t'($signed(trig.sn[5]));
        c1 = lfk_pkg::op_t'($signed(trig.cs[0]));
        c2 = lfk_pkg::op_t'($signed(trig.cs[1]));
        c3 = lfk_pkg::op_t'($signed(trig.cs[2]));
        c4 = lfk_pkg::op_t'($signed(trig.cs[3]));
        c5 = lfk_pkg::op_t'($signed(trig.cs[4]));
        c6 = lfk_pkg::op_t'($signed(trig.cs[5]));
        th = lfk_pkg::op_t'($signed({1'b0, lens.thigh}));
        ca = lfk_pkg::op_t'($signed({1'b0, lens.calf}));
        an = lfk_pkg::op_t'($signed({1'b0, lens.ankle}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // pairwise trig products and the two calf-length products
            a_s1c3_reg <= lfk_pkg::qmul(s1, c3);
            a_c4c5_reg <= lfk_pkg::qmul(c4, c5);
            a_s4s5_reg <= lfk_pkg::qmul(s4, s5);
            a_s1s3_reg <= lfk_pkg::qmul(s1, s3);
            a_s4c5_reg <= lfk_pkg::qmul(s4, c5);
            a_c4s5_reg <= lfk_pkg::qmul(c4, s5);
            a_c1c2_reg <= lfk_pkg::qmul(c1, c2);
            a_s3c1_reg <= lfk_pkg::qmul(s3, c1);
            a_c1s2_reg <= lfk_pkg::qmul(c1, s2);
            a_s2s3_reg <= lfk_pkg::qmul(s2, s3);
            a_s2c3_reg <= lfk_pkg::qmul(s2, c3);
            a_s1c2_reg <= lfk_pkg::qmul(s1, c2);
            a_c1s3_reg <= lfk_pkg::qmul(c1, s3);
            a_s3s1_reg <= lfk_pkg::qmul(s3, s1);
            a_c1c3_reg <= lfk_pkg::qmul(c1, c3);
            a_c2s6_reg <= lfk_pkg::qmul(c2, s6);
            a_c2c6_reg <= lfk_pkg::qmul(c2, c6);
            a_kc_reg   <= lfk_pkg::qmul(c4, ca);
            a_ko_reg   <= lfk_pkg::qmul(s4, ca);
            a_c2_reg   <= c2;
            a_c3_reg   <= c3;
            a_c6_reg   <= c6;
            a_s6_reg   <= s6;

            // triple products and ankle angle sums
            b_c1c2c3_reg <= lfk_pkg::qmul(a_c1c2_reg, a_c3_reg);
            b_s3c1c2_reg <= lfk_pkg::qmul(a_s3c1_reg, a_c2_reg);
            b_s1c2c3_reg <= lfk_pkg::qmul(a_s1c2_reg, a_c3_reg);
            b_s3s1c2_reg <= lfk_pkg::qmul(a_s3s1_reg, a_c2_reg);
            b_c1s2s6_reg <= lfk_pkg::qmul(a_c1s2_reg, a_s6_reg);
            b_c1s2c6_reg <= lfk_pkg::qmul(a_c1s2_reg, a_c6_reg);
            b_s2c3c6_reg <= lfk_pkg::qmul(a_s2c3_reg, a_c6_reg);
            b_s2c3s6_reg <= lfk_pkg::qmul(a_s2c3_reg, a_s6_reg);
            b_dif_reg    <= a_c4c5_reg - a_s4s5_reg;
            b_sum_reg    <= a_s4c5_reg + a_c4s5_reg;
            b_ms2s3_reg  <= -a_s2s3_reg;
            b_leg_reg    <= a_kc_reg + th;
            b_ko_reg     <= a_ko_reg;
            b_s1s3_reg   <= a_s1s3_reg;
            b_s1c3_reg   <= a_s1c3_reg;
            b_c1s3_reg   <= a_c1s3_reg;
            b_c1c3_reg   <= a_c1c3_reg;
            b_s2c3_reg   <= a_s2c3_reg;
            b_c2s6_reg   <= a_c2s6_reg;
            b_c2c6_reg   <= a_c2c6_reg;
            b_c6_reg     <= a_c6_reg;
            b_s6_reg     <= a_s6_reg;

            c_ra_reg  <= b_c1c2c3_reg - b_s1s3_reg;
            c_rb_reg  <= -b_s3c1c2_reg - b_s1c3_reg;
            c_ya_reg  <= b_s1c2c3_reg + b_c1s3_reg;
            c_yb_reg  <= -b_s3s1c2_reg + b_c1c3_reg;
            c_m31_reg <= lfk_pkg::qmul(b_s2c3c6_reg, b_dif_reg);
            c_m32_reg <= lfk_pkg::qmul(b_s2c3s6_reg, -b_dif_reg);
            c_t31_reg <= lfk_pkg::qmul(b_ms2s3_reg, b_sum_reg);
            c_t32_reg <= lfk_pkg::qmul(b_ms2s3_reg, -b_sum_reg);
            c_r33_reg <= lfk_pkg::qmul(b_s2c3_reg, b_sum_reg)
                       + lfk_pkg::qmul(b_ms2s3_reg, -b_dif_reg);
            c_pxa_reg <= lfk_pkg::qmul(b_s2c3_reg, b_leg_reg)
                       + lfk_pkg::qmul(b_ms2s3_reg, b_ko_reg);
            c_dif_reg    <= b_dif_reg;
            c_sum_reg    <= b_sum_reg;
            c_leg_reg    <= b_leg_reg;
            c_ko_reg     <= b_ko_reg;
            c_c1s2s6_reg <= b_c1s2s6_reg;
            c_c1s2c6_reg <= b_c1s2c6_reg;
            c_c2s6_reg   <= b_c2s6_reg;
            c_c2c6_reg   <= b_c2c6_reg;
            c_c6_reg     <= b_c6_reg;
            c_s6_reg     <= b_s6_reg;

            d_x1_reg  <= lfk_pkg::qmul(c_ra_reg, c_dif_reg);
            d_x2_reg  <= lfk_pkg::qmul(c_rb_reg, c_sum_reg);
            d_x3_reg  <= lfk_pkg::qmul(c_ra_reg, -c_dif_reg);
            d_x4_reg  <= lfk_pkg::qmul(c_rb_reg, -c_sum_reg);
            d_r13_reg <= lfk_pkg::qmul(c_ra_reg, c_sum_reg)
                       + lfk_pkg::qmul(c_rb_reg, -c_dif_reg);
            d_r31_reg <= c_m31_reg + lfk_pkg::qmul(c_t31_reg, c_c6_reg) + c_c2s6_reg;
            d_r32_reg <= c_m32_reg + lfk_pkg::qmul(c_t32_reg, c_s6_reg) + c_c2c6_reg;
            d_r33_reg <= c_r33_reg;
            d_pxa_reg <= c_pxa_reg;
            d_pya_reg <= lfk_pkg::qmul(c_ya_reg, c_leg_reg) + lfk_pkg::qmul(c_yb_reg, c_ko_reg);
            d_pza_reg <= lfk_pkg::qmul(c_ra_reg, c_leg_reg) + lfk_pkg::qmul(c_rb_reg, c_ko_reg);
            d_c1s2s6_reg <= c_c1s2s6_reg;
            d_c1s2c6_reg <= c_c1s2c6_reg;
            d_c6_reg     <= c_c6_reg;
            d_s6_reg     <= c_s6_reg;

            e_r11_reg <= lfk_pkg::qmul(d_x1_reg, d_c6_reg) + lfk_pkg::qmul(d_x2_reg, d_c6_reg)
                       - d_c1s2s6_reg;
            e_r12_reg <= lfk_pkg::qmul(d_x3_reg, d_s6_reg) + lfk_pkg::qmul(d_x4_reg, d_s6_reg)
                       - d_c1s2c6_reg;
            e_r13_reg <= d_r13_reg;
            e_r31_reg <= d_r31_reg;
            e_r32_reg <= d_r32_reg;
            e_r33_reg <= d_r33_reg;
            e_px_reg  <= d_pxa_reg + lfk_pkg::qmul(d_r13_reg, an);
            e_pya_reg <= d_pya_reg;
            e_pza_reg <= d_pza_reg;

            // middle row from the unsaturated outer rows
            f_res_reg.r11 <= e_r11_reg;
            f_res_reg.r12 <= e_r12_reg;
            f_res_reg.r13 <= e_r13_reg;
            f_res_reg.r21 <= lfk_pkg::qmul(e_r12_reg, e_r33_reg)
                           - lfk_pkg::qmul(e_r13_reg, e_r32_reg);
            f_res_reg.r22 <= lfk_pkg::qmul(e_r13_reg, e_r31_reg)
                           - lfk_pkg::qmul(e_r11_reg, e_r33_reg);
            f_res_reg.r23 <= lfk_pkg::qmul(e_r11_reg, e_r32_reg)
                           - lfk_pkg::qmul(e_r12_reg, e_r31_reg);
            f_res_reg.r31 <= e_r31_reg;
            f_res_reg.r32 <= e_r32_reg;
            f_res_reg.r33 <= e_r33_reg;
            f_res_reg.px  <= e_px_reg;
            f_res_reg.py  <= e_pya_reg + lfk_pkg::qmul(e_r12_reg, an);
            f_res_reg.pz  <= e_pza_reg + lfk_pkg::qmul(e_r11_reg, an);
        end
    end

    assign res = f_res_reg;

endmodule

[rtl/core/leg_forward_kinematics_unit.sv]
// path: an input transfer passes the sine stages, the product stages and an output register to the m_ side
// throughput: one pose per cycle; twelve sine units and the product pipeline
// all advance together, so the whole pipeline holds while a result waits on m_tready
// reset: aresetn (sync, active low) clears all valid bits and loads the
// default segment lengths; no clearing pass, no memories
// depends on lfk_pkg, lfk_sine, lfk_kinematics

module leg_forward_kinematics_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // hip_yaw, hip_roll, hip_pitch, knee_angle, foot_pitch, foot_roll (16 bits each)
    input  logic [95:0]  s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_11..rot_33 (16 bits each), pos_x, pos_y, pos_z (19 bits each), 7 zero bits
    output logic [207:0] m_tdata
);

    logic [15:0] thigh_len_reg, calf_len_reg, ankle_len_reg;
    logic [lfk_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic        m_tvalid_reg;
    logic [207:0] m_tdata_reg;
    logic        en;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    lfk_pkg::trig_set_t trig;
    lfk_pkg::len_cfg_t  lens;
    lfk_pkg::kin_res_t  res;

    function automatic logic [15:0] sat_rot(input lfk_pkg::op_t v);
        lfk_pkg::op_t c;
        c = (v > lfk_pkg::ROT_MAX) ? lfk_pkg::ROT_MAX :
            ((v < lfk_pkg::ROT_MIN) ? lfk_pkg::ROT_MIN : v);
        return c[15:0];
    endfunction

    function automatic logic [18:0] sat_pos(input lfk_pkg::op_t v);
        lfk_pkg::op_t c;
        c = (v > lfk_pkg::POS_MAX) ? lfk_pkg::POS_MAX :
            ((v < lfk_pkg::POS_MIN) ? lfk_pkg::POS_MIN : v);
        return c[18:0];
    endfunction

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thigh_len_reg <= 16'd23808;
            calf_len_reg  <= 16'd23808;
            ankle_len_reg <= 16'd8576;
        end else if (cfg_wr) begin
            case (cfg_idx)
                lfk_pkg::REG_THIGH: thigh_len_reg <= pwdata[15:0];
                lfk_pkg::REG_CALF:  calf_len_reg  <= pwdata[15:0];
                lfk_pkg::REG_ANKLE: ankle_len_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lfk_pkg::REG_THIGH: prdata = {16'd0, thigh_len_reg};
            lfk_pkg::REG_CALF:  prdata = {16'd0, calf_len_reg};
            lfk_pkg::REG_ANKLE: prdata = {16'd0, ankle_len_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign lens.thigh = thigh_len_reg;
    assign lens.calf  = calf_len_reg;
    assign lens.ankle = ankle_len_reg;

    genvar gi;
    generate
        for (gi = 0; gi < 6; gi++) begin : g_joint
            lfk_sine u_sin (
                .aclk   (aclk),
                .en     (en),
                .angle  (lfk_pkg::ang_t'($signed(s_tdata[gi*16 +: 16]))),
                .result (trig.sn[gi])
            );
            // cosine as the sine of the angle plus a quarter turn
            lfk_sine u_cos (
                .aclk   (aclk),
                .en     (en),
                .angle  (lfk_pkg::ang_t'($signed(s_tdata[gi*16 +: 16])) + lfk_pkg::ANG_HALF),
                .result (trig.cs[gi])
            );
        end
    endgenerate

    lfk_kinematics u_kin (
        .aclk (aclk),
        .en   (en),
        .trig (trig),
        .lens (lens),
        .res  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            valid_reg    <= {valid_reg[lfk_pkg::PIPE_DEPTH-2:0], s_tvalid};
            m_tvalid_reg <= valid_reg[lfk_pkg::PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {7'd0,
                            sat_pos(res.pz), sat_pos(res.py), sat_pos(res.px),
                            sat_rot(res.r33), sat_rot(res.r32), sat_rot(res.r31),
                            sat_rot(res.r23), sat_rot(res.r22), sat_rot(res.r21),
                            sat_rot(res.r13), sat_rot(res.r12), sat_rot(res.r11)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
